// File: rtl/kcls_pkg.sv
// kcls_pkg: constants, register indexes and the result record for the key combo
// link selector. No dependencies; imported by key_combo_link_selector_unit.
package kcls_pkg;

  localparam int LINK_CHOICES  = 5;
  localparam int REVISION_BITS = 8;

  // field widths fixed by the stream format
  localparam int TIME_W  = 32;
  localparam int KEY_W   = 6;   // choice keys plus battery key
  localparam int REL_W   = 7;   // choice keys, battery, Fn
  localparam int REV_W   = 8;
  localparam int AVAIL_W = 5;
  localparam int LINK_W  = 3;
  localparam int ERR_W   = 16;
  localparam int TMO_W   = 16;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam int BATTERY_BIT = LINK_CHOICES;
  localparam int FN_BIT      = LINK_CHOICES + 1;

  localparam logic [LINK_W-1:0] USB_LINK    = 3'd4;
  localparam logic [LINK_W-1:0] START_RESET = 3'd4;
  localparam logic [TMO_W-1:0]  TMO_RESET   = 16'd2000;
  localparam logic [ERR_W-1:0]  ERR_MAX     = 16'hFFFF;

  // revision compare mask, clipped to the 8-bit field
  localparam logic [REV_W-1:0] REV_MASK = REV_W'((64'd1 << REVISION_BITS) - 64'd1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_LINK = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 8'd1;

  // item kinds on in_tuser
  localparam logic ACT_SCAN    = 1'b0;
  localparam logic ACT_SERVICE = 1'b1;

  typedef struct packed {
    logic [ERR_W-1:0]  error_total;
    logic              report_reset;
    logic              select_attempt;
    logic              battery_view;
    logic              label_stop;
    logic [2:0]        label_start;
    logic              switch_busy;
    logic [LINK_W-1:0] active_link;
    logic              kbd_mode_req;
    logic              midi_hold;
    logic              consumed;
  } result_t;

endpackage

// File: rtl/key_combo_link_selector_unit.sv
// key_combo_link_selector_unit: Fn + key link selection with hysteresis, pending
// confirm, link switch supervision and error count. Depends on kcls_pkg.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  in_     | in  | in_tvalid/tready   | tuser: action; tdata: scan/service fields
//  out_    | out | out_tvalid/tready  | tdata: one result record per input beat
//  cfg_    | in  | cfg_valid/ready    | cfg_index, cfg_data (register write)
//
//  One beat per cycle sustained while the output is not stalled: an input register
//  feeds a single pass of compare/select logic and one 32-bit subtract/compare for
//  the timeout, whose result lands in the output register, which drives out_tvalid.
//  rst_n is synchronous, active low; state returns to start link 4, timeout 2000.
//  A stalled output holds its beat; the input register keeps taking beats while
//  the output is free or being taken. cfg_ready is always high; the user must make
//  writes only while the block is idle, as the block itself does not enforce it.
module key_combo_link_selector_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [31:0] time_ms, [32] frame_ok, [38:33] below_press, [45:39] within_release,
  // [46] all_released, [47] fn_armed_down, [55:48] scan_revision,
  // [60:56] available_mask, [61] host_idle, [62] select_done, [63] zero
  input  logic [kcls_pkg::IN_DATA_W-1:0]  in_tdata,
  // [0] action
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [0] consumed, [1] midi_hold, [2] kbd_mode_req, [5:3] active_link,
  // [6] switch_busy, [9:7] label_start, [10] label_stop, [11] battery_view,
  // [12] select_attempt, [13] report_reset, [29:14] error_total, [31:30] zero
  output logic [kcls_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kcls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kcls_pkg::CFG_DATA_W-1:0] cfg_data
);
  import kcls_pkg::*;

  // configuration
  logic [TMO_W-1:0]  timeout_r;

  // block state
  logic [LINK_W-1:0] current_link_r, current_link_nxt;
  logic [LINK_W-1:0] target_link_r,  target_link_nxt;
  logic              switching_r,    switching_nxt;
  logic [2:0]        pending_r,      pending_nxt;
  logic [KEY_W-1:0]  held_keys_r,    held_keys_nxt;
  logic              need_neutral_r, need_neutral_nxt;
  logic              battery_r,      battery_nxt;
  logic [REV_W-1:0]  saved_rev_r,    saved_rev_nxt;
  logic [TIME_W-1:0] req_time_r,     req_time_nxt;
  logic [ERR_W-1:0]  error_r,        error_nxt;

  // input register
  logic                 s1_valid_r;
  logic [IN_DATA_W-1:0] s1_data_r;
  logic                 s1_action_r;
  logic                 s1_adv;

  // output register
  logic    o_valid_r;
  result_t o_res_r;
  result_t res;

  // unpacked fields of the held beat
  logic [TIME_W-1:0]  f_time;
  logic               f_ok;
  logic [KEY_W-1:0]   f_below;
  logic [REL_W-1:0]   f_within;
  logic               f_all_rel;
  logic               f_fn_down;
  logic [REV_W-1:0]   f_rev;
  logic [AVAIL_W-1:0] f_avail;
  logic               f_idle;
  logic               f_sel_ok;

  logic [KEY_W-1:0]  held, edges;
  logic [7:0]        held_ext, avail_ext;
  logic              fn, busy, cancelled, keep, single;
  logic [2:0]        pidx, eidx;
  logic [TIME_W-1:0] elapsed;
  logic              cfg_start_ok, cfg_we;

  assign f_time    = s1_data_r[31:0];
  assign f_ok      = s1_data_r[32];
  assign f_below   = s1_data_r[38:33];
  assign f_within  = s1_data_r[45:39];
  assign f_all_rel = s1_data_r[46];
  assign f_fn_down = s1_data_r[47];
  assign f_rev     = s1_data_r[55:48] & REV_MASK;
  assign f_avail   = s1_data_r[60:56];
  assign f_idle    = s1_data_r[61];
  assign f_sel_ok  = s1_data_r[62];

  // handshakes
  assign s1_adv     = s1_valid_r && (!o_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_adv;
  assign out_tvalid = o_valid_r;
  assign out_tdata  = {2'b00, o_res_r};
  assign cfg_ready  = 1'b1;
  assign cfg_we     = cfg_valid && cfg_ready;
  assign cfg_start_ok = cfg_data[LINK_W-1:0] <= USB_LINK;

  // hysteresis and edge pick
  assign held  = (held_keys_r & f_within[KEY_W-1:0]) | (~held_keys_r & f_below);
  assign edges = held & ~held_keys_r;
  assign fn    = f_within[FN_BIT];
  assign held_ext  = {{(8-KEY_W){1'b0}}, held};
  assign avail_ext = {{(8-AVAIL_W){1'b0}}, f_avail};
  assign single    = (edges != '0) && ((edges & (edges - KEY_W'(1))) == '0);
  assign pidx      = pending_r - 3'd1;
  assign cancelled = saved_rev_r != f_rev;
  assign keep      = !cancelled && fn && held_ext[pidx];
  assign busy      = (current_link_r != USB_LINK) || switching_r;
  assign elapsed   = f_time - req_time_r;

  // lowest set edge bit
  always_comb begin
    eidx = '0;
    for (int i = KEY_W - 1; i >= 0; i--) begin
      if (edges[i]) eidx = 3'(i);
    end
  end

  always_comb begin
    current_link_nxt = current_link_r;
    target_link_nxt  = target_link_r;
    switching_nxt    = switching_r;
    pending_nxt      = pending_r;
    held_keys_nxt    = held_keys_r;
    need_neutral_nxt = need_neutral_r;
    battery_nxt      = battery_r;
    saved_rev_nxt    = saved_rev_r;
    req_time_nxt     = req_time_r;
    error_nxt        = error_r;
    res              = '0;

    if (s1_action_r == ACT_SCAN) begin
      res.midi_hold    = busy;
      res.kbd_mode_req = busy;
      if (!f_ok) begin
        pending_nxt   = '0;
        held_keys_nxt = '0;
        battery_nxt   = 1'b0;
        res.label_stop = 1'b1;
      end else if (switching_r) begin
        res.consumed = 1'b1;
      end else if (need_neutral_r) begin
        if (f_all_rel) need_neutral_nxt = 1'b0;
        res.consumed = 1'b1;
      end else begin
        held_keys_nxt = held;
        if (pending_r != '0) begin
          res.consumed = 1'b1;
          if (!keep) begin
            pending_nxt      = '0;
            battery_nxt      = 1'b0;
            res.label_stop   = 1'b1;
            need_neutral_nxt = 1'b1;
            if (!cancelled && (pidx < 3'(LINK_CHOICES)) && (current_link_r != pidx)) begin
              target_link_nxt  = pidx;
              switching_nxt    = 1'b1;
              req_time_nxt     = f_time;
              res.kbd_mode_req = 1'b1;
              res.report_reset = 1'b1;
            end
          end
        end else if (f_fn_down && single) begin
          // an unavailable link choice is not taken; the battery key always is
          if (!((eidx < 3'(LINK_CHOICES)) && !avail_ext[eidx])) begin
            pending_nxt   = eidx + 3'd1;
            saved_rev_nxt = f_rev;
            battery_nxt   = eidx == 3'(BATTERY_BIT);
            if (eidx != 3'(BATTERY_BIT)) res.label_start = eidx + 3'd1;
            res.consumed = 1'b1;
          end
        end
      end
    end else begin
      if (!f_ok) begin
        if (switching_r && (error_r != ERR_MAX)) error_nxt = error_r + ERR_W'(1);
        pending_nxt      = '0;
        held_keys_nxt    = '0;
        switching_nxt    = 1'b0;
        battery_nxt      = 1'b0;
        need_neutral_nxt = 1'b1;
        res.label_stop   = 1'b1;
      end else if (switching_r) begin
        if (elapsed >= {16'd0, timeout_r}) begin
          if (error_r != ERR_MAX) error_nxt = error_r + ERR_W'(1);
          switching_nxt    = 1'b0;
          need_neutral_nxt = 1'b1;
        end else if (f_idle) begin
          res.select_attempt = 1'b1;
          if (f_sel_ok) begin
            current_link_nxt = target_link_r;
            switching_nxt    = 1'b0;
            need_neutral_nxt = 1'b1;
            res.report_reset = 1'b1;
          end
        end
      end
      res.midi_hold = (current_link_nxt != USB_LINK) || switching_nxt;
    end

    res.active_link  = current_link_nxt;
    res.switch_busy  = switching_nxt;
    res.battery_view = battery_nxt;
    res.error_total  = error_nxt;
  end

  // configuration and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r      <= TMO_RESET;
      current_link_r <= START_RESET;
      target_link_r  <= START_RESET;
      switching_r    <= 1'b0;
      pending_r      <= '0;
      held_keys_r    <= '0;
      need_neutral_r <= 1'b0;
      battery_r      <= 1'b0;
      saved_rev_r    <= '0;
      req_time_r     <= '0;
      error_r        <= '0;
    end else if (cfg_we && (cfg_index == CFG_START_LINK)) begin
      if (cfg_start_ok) begin
        // rebind: all selector state back to reset around the new link; timeout is kept
        current_link_r <= cfg_data[LINK_W-1:0];
        target_link_r  <= cfg_data[LINK_W-1:0];
        switching_r    <= 1'b0;
        pending_r      <= '0;
        held_keys_r    <= '0;
        need_neutral_r <= 1'b0;
        battery_r      <= 1'b0;
        saved_rev_r    <= '0;
        req_time_r     <= '0;
        error_r        <= '0;
      end
    end else if (cfg_we && (cfg_index == CFG_TIMEOUT)) begin
      timeout_r <= cfg_data[TMO_W-1:0];
    end else if (s1_adv) begin
      current_link_r <= current_link_nxt;
      target_link_r  <= target_link_nxt;
      switching_r    <= switching_nxt;
      pending_r      <= pending_nxt;
      held_keys_r    <= held_keys_nxt;
      need_neutral_r <= need_neutral_nxt;
      battery_r      <= battery_nxt;
      saved_rev_r    <= saved_rev_nxt;
      req_time_r     <= req_time_nxt;
      error_r        <= error_nxt;
    end
  end

  // input and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (s1_adv) o_valid_r <= 1'b1;
      else if (out_tready) o_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_data_r   <= in_tdata;
      s1_action_r <= in_tuser;
    end
    if (s1_adv) o_res_r <= res;
  end

  // a running switch always heads for a different link
  a_switch_target: assert property (@(posedge clk) disable iff (!rst_n)
    switching_r |-> (current_link_r != target_link_r))
    else $error("switch running towards the current link");

  // a pending choice only exists outside a switch and outside neutral wait
  a_pending_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (pending_r != '0) |-> (!switching_r && !need_neutral_r))
    else $error("pending choice during switch or neutral wait");

  // error count only steps by one, or returns to zero on rebind
  a_err_step: assert property (@(posedge clk) disable iff (!rst_n)
    (error_r != $past(error_r)) |->
      ((error_r == $past(error_r) + ERR_W'(1)) || (error_r == '0)))
    else $error("error count jumped");

  // a label is never started together with the battery view
  a_label_batt: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && (o_res_r.label_start != '0)) |-> !o_res_r.battery_view)
    else $error("label start with battery view");

endmodule

// File: tb/kcls_checker.sv
// kcls_checker: watches the in_, out_ and cfg_ channels of the key combo link
// selector, predicts every result beat and compares it field by field.
// Depends on kcls_pkg for widths, register indexes and result_t.
module kcls_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [kcls_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [kcls_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [kcls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kcls_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [31:0]                     fail_count,
  output logic [31:0]                     results_checked,
  output logic [31:0]                     awaiting,
  output logic [kcls_pkg::ERR_W-1:0]      error_level
);
  import kcls_pkg::*;

  // in_tdata layout, top bit first
  typedef struct packed {
    logic               pad;
    logic               select_done;
    logic               host_idle;
    logic [AVAIL_W-1:0] avail;
    logic [REV_W-1:0]   rev;
    logic               fn_armed;
    logic               all_rel;
    logic [REL_W-1:0]   rel_lvl;
    logic [KEY_W-1:0]   below;
    logic               frame_ok;
    logic [TIME_W-1:0]  time_ms;
  } key_beat_t;

  result_t     awaited_results[$];
  int unsigned n_fail = 0;
  int unsigned n_checked = 0;
  int unsigned n_wait = 0;

  // predicted selector state
  logic [LINK_W-1:0] start_cfg, link_now, link_goal;
  logic [TMO_W-1:0]  tmo_cfg;
  logic              switch_run, want_neutral, batt_on;
  logic [2:0]        pend_choice;
  logic [KEY_W-1:0]  held_mask;
  logic [REV_W-1:0]  rev_saved;
  logic [TIME_W-1:0] req_ms;
  logic [ERR_W-1:0]  err_cnt;

  assign fail_count      = n_fail;
  assign results_checked = n_checked;
  assign awaiting        = n_wait;

  task automatic rebind(input logic [LINK_W-1:0] link);
    link_now     = link;
    link_goal    = link;
    switch_run   = 1'b0;
    pend_choice  = '0;
    held_mask    = '0;
    want_neutral = 1'b0;
    batt_on      = 1'b0;
    rev_saved    = '0;
    req_ms       = '0;
    err_cnt      = '0;
  endtask

  function automatic result_t link_outcome(input logic kind, input key_beat_t b);
    result_t           r;
    logic [KEY_W-1:0]  nxt_held, edges;
    logic [2:0]        idx;
    logic              cancelled, busy;
    logic [TIME_W-1:0] span;
    r   = '0;
    idx = '0;
    if (kind == ACT_SCAN) begin
      busy           = (link_now != USB_LINK) || switch_run;
      r.midi_hold    = busy;
      r.kbd_mode_req = busy;
      if (!b.frame_ok) begin
        pend_choice  = '0;
        held_mask    = '0;
        batt_on      = 1'b0;
        r.label_stop = 1'b1;
      end else if (switch_run) begin
        r.consumed = 1'b1;
      end else if (want_neutral) begin
        if (b.all_rel) want_neutral = 1'b0;
        r.consumed = 1'b1;
      end else begin
        // hysteresis: held keys stay until above release, others need press level
        nxt_held  = (held_mask & b.rel_lvl[KEY_W-1:0]) | (~held_mask & b.below);
        edges     = nxt_held & ~held_mask;
        held_mask = nxt_held;
        if (pend_choice != '0) begin
          idx        = pend_choice - 3'd1;
          cancelled  = (rev_saved & REV_MASK) != (b.rev & REV_MASK);
          r.consumed = 1'b1;
          if (cancelled || !b.rel_lvl[FN_BIT] || !nxt_held[idx]) begin
            pend_choice  = '0;
            batt_on      = 1'b0;
            r.label_stop = 1'b1;
            want_neutral = 1'b1;
            if (!cancelled && idx < 3'(LINK_CHOICES) && link_now != idx) begin
              link_goal      = idx;
              switch_run     = 1'b1;
              req_ms         = b.time_ms;
              r.kbd_mode_req = 1'b1;
              r.report_reset = 1'b1;
            end
          end
        end else if (b.fn_armed && edges != '0 && (edges & (edges - KEY_W'(1))) == '0) begin
          for (int i = 0; i < KEY_W; i++)
            if (edges[i]) idx = 3'(i);
          // battery key is always available; a link key needs its mask bit
          if (idx == 3'(BATTERY_BIT) || b.avail[idx]) begin
            pend_choice = idx + 3'd1;
            rev_saved   = b.rev & REV_MASK;
            batt_on     = (idx == 3'(BATTERY_BIT));
            if (!batt_on) r.label_start = idx + 3'd1;
            r.consumed = 1'b1;
          end
        end
      end
    end else begin
      if (!b.frame_ok) begin
        if (switch_run && err_cnt != ERR_MAX) err_cnt = err_cnt + 1'b1;
        pend_choice  = '0;
        held_mask    = '0;
        switch_run   = 1'b0;
        batt_on      = 1'b0;
        want_neutral = 1'b1;
        r.label_stop = 1'b1;
      end else if (switch_run) begin
        span = b.time_ms - req_ms;
        if (span >= {16'd0, tmo_cfg}) begin
          if (err_cnt != ERR_MAX) err_cnt = err_cnt + 1'b1;
          switch_run   = 1'b0;
          want_neutral = 1'b1;
        end else if (b.host_idle) begin
          r.select_attempt = 1'b1;
          if (b.select_done) begin
            link_now       = link_goal;
            switch_run     = 1'b0;
            want_neutral   = 1'b1;
            r.report_reset = 1'b1;
          end
        end
      end
      r.midi_hold = (link_now != USB_LINK) || switch_run;
    end
    r.active_link  = link_now;
    r.switch_busy  = switch_run;
    r.battery_view = batt_on;
    r.error_total  = err_cnt;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want, got;
    if (!rst_n) begin
      start_cfg = START_RESET;
      tmo_cfg   = TMO_RESET;
      rebind(START_RESET);
      awaited_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_START_LINK: begin
            // out-of-range links are dropped without a rebind
            if (cfg_data[LINK_W-1:0] <= USB_LINK) begin
              start_cfg = cfg_data[LINK_W-1:0];
              rebind(start_cfg);
            end
          end
          CFG_TIMEOUT: tmo_cfg = cfg_data[TMO_W-1:0];
          default: ;
        endcase
      end
      // retire before predicting, so a stray beat never meets a fresh expectation
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          $error("result beat %h with nothing awaited", out_tdata);
          n_fail++;
        end else begin
          want = awaited_results.pop_front();
          got  = result_t'(out_tdata[$bits(result_t)-1:0]);
          n_checked++;
          check_field("consumed", 32'(want.consumed), 32'(got.consumed));
          check_field("midi_hold", 32'(want.midi_hold), 32'(got.midi_hold));
          check_field("kbd_mode_req", 32'(want.kbd_mode_req), 32'(got.kbd_mode_req));
          check_field("active_link", 32'(want.active_link), 32'(got.active_link));
          check_field("switch_busy", 32'(want.switch_busy), 32'(got.switch_busy));
          check_field("label_start", 32'(want.label_start), 32'(got.label_start));
          check_field("label_stop", 32'(want.label_stop), 32'(got.label_stop));
          check_field("battery_view", 32'(want.battery_view), 32'(got.battery_view));
          check_field("select_attempt", 32'(want.select_attempt),
                      32'(got.select_attempt));
          check_field("report_reset", 32'(want.report_reset), 32'(got.report_reset));
          check_field("error_total", 32'(want.error_total), 32'(got.error_total));
          check_field("padding", 32'd0, 32'(out_tdata[OUT_DATA_W-1:$bits(result_t)]));
        end
      end
      if (in_tvalid && in_tready)
        awaited_results.push_back(link_outcome(in_tuser, key_beat_t'(in_tdata)));
    end
    n_wait      = awaited_results.size();
    error_level = err_cnt;
  end

endmodule

// File: tb/key_combo_link_selector_unit_tb.sv
// key_combo_link_selector_unit_tb: stimulus and verdict for the key combo link
// selector. Depends on kcls_pkg, key_combo_link_selector_unit and kcls_checker.
module key_combo_link_selector_unit_tb;
  import kcls_pkg::*;

  localparam int HOLD_OFF_CYCLES = 80;    // long sink stall to back the pipe up
  localparam int TAIL_CYCLES     = 8;     // idle wait after the final drain
  localparam int PHASES          = 7;
  localparam int PHASE_BEATS     = 206;
  localparam int SAT_ROUNDS      = 6;     // one failed switch per round

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid, in_tready, in_tuser;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid, out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic [31:0]           fail_count, results_checked, awaiting;
  logic [ERR_W-1:0]      error_level;

  // stimulus control shared with the sink process
  bit                    hold_req  = 1'b0;  // ask the sink for one long stall
  bit                    rx_free   = 1'b0;  // sink always ready
  bit                    tx_free   = 1'b0;  // source never idles
  bit                    clock_run = 1'b0;  // let the millisecond time drift
  logic [TIME_W-1:0]     now_ms    = 32'hFFFF_FC00;
  int unsigned           beats_sent = 0;

  // link / timeout pairs per random phase: both ends of each register included
  logic [LINK_W-1:0]     start_tab [PHASES] = '{3'd4, 3'd0, 3'd3, 3'd2, 3'd1, 3'd4, 3'd0};
  logic [TMO_W-1:0]      tmo_tab   [PHASES] = '{16'd2000, 16'd65535, 16'd1, 16'd0,
                                               16'd300, 16'd20, 16'd5};

  key_combo_link_selector_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  kcls_checker i_link_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .results_checked (results_checked),
    .awaiting        (awaiting),
    .error_level     (error_level)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Safety net: a healthy run ends far earlier than this.
  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Result sink. Mostly ready, short stalls often, long ones rarely; a requested
  // hold-off is counted out here while the source keeps offering beats.
  initial begin : result_sink
    int unsigned r, n;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (rx_free) begin
        out_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_tready <= 1'b1;
        end else begin
          n = (r < 93) ? $urandom_range(1, 3) : $urandom_range(8, 30);
          out_tready <= 1'b0;
          repeat (n - 1) @(negedge clk);
        end
      end
    end
  end

  // One input beat: time_ms in the low word, the remaining fields above it.
  // valid stays high between back-to-back beats; a gap lowers it once.
  task automatic push_beat(input logic kind, input logic [30:0] fields);
    int unsigned r, gap;
    if (clock_run) begin
      r = $urandom_range(0, 99);
      if (r < 80)      now_ms = now_ms + $urandom_range(0, 20);
      else if (r < 95) now_ms = now_ms + $urandom_range(0, 3000);
      else if (r < 99) now_ms = now_ms + $urandom_range(0, 70000);
      else             now_ms = $urandom;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {1'b0, fields, now_ms};
    do @(posedge clk); while (!in_tready);
    beats_sent++;
    if (!tx_free) begin
      r   = $urandom_range(0, 99);
      gap = (r < 65) ? 0 : (r < 93) ? $urandom_range(1, 3) : $urandom_range(8, 30);
      if (gap != 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // scan frame; host fields are don't-care here so they are randomised
  task automatic scan_beat(input logic fok, input logic [KEY_W-1:0] below,
                           input logic [REL_W-1:0] rel_lvl, input logic rel_all,
                           input logic fn, input logic [REV_W-1:0] rev,
                           input logic [AVAIL_W-1:0] avail);
    push_beat(ACT_SCAN, {1'($urandom), 1'($urandom), avail, rev, fn, rel_all,
                         rel_lvl, below, fok});
  endtask

  // service tick; key fields are don't-care here
  task automatic tick_beat(input logic fok, input logic idle, input logic sel);
    push_beat(ACT_SERVICE, {sel, idle, 5'($urandom), 8'($urandom), 1'($urandom),
                            1'($urandom), 7'($urandom), 6'($urandom), fok});
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stop offering and wait for every predicted result beat to come out
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
  endtask

  // Mostly a well-formed Fn combo (neutral, press, hold, release, ticks) with
  // random content and random ways of breaking it; the rest is raw noise.
  task automatic random_traffic();
    int unsigned      k, r, n;
    logic [REV_W-1:0] rev;
    logic [AVAIL_W-1:0] avail;
    logic [REL_W-1:0] kbit, rel;
    if ($urandom_range(0, 99) < 12) begin
      push_beat(1'($urandom), 31'($urandom));
    end else begin
      k     = $urandom_range(0, KEY_W - 1);
      kbit  = 7'd1 << k;
      rev   = REV_W'($urandom);
      avail = AVAIL_W'($urandom);
      if (k < LINK_CHOICES && $urandom_range(0, 99) < 85) avail[k] = 1'b1;
      if ($urandom_range(0, 99) < 60)
        scan_beat(1'b1, 6'd0, 7'd0, 1'b1, 1'b0, rev, avail);
      // press while Fn is held; now and then a messy press or no armed Fn
      r = $urandom_range(0, 99);
      scan_beat($urandom_range(0, 99) < 97,
                (r < 10) ? 6'($urandom) : kbit[KEY_W-1:0],
                (r < 5) ? 7'($urandom) : 7'h40, 1'b0,
                $urandom_range(0, 99) < 92, rev, avail);
      n = $urandom_range(0, 2);
      repeat (n)
        scan_beat(1'b1, ($urandom_range(0, 99) < 30) ? 6'($urandom) : 6'd0,
                  kbit | 7'h40, 1'b0, 1'b1, rev, avail);
      // confirm by dropping Fn or the key, or spoil it with a new revision
      r = $urandom_range(0, 99);
      rel = (r < 45) ? kbit : (r < 80) ? 7'h40 : (r < 90) ? (kbit | 7'h40) : 7'd0;
      if (r >= 80 && r < 90) rev = rev ^ (8'd1 << $urandom_range(0, 7));
      scan_beat($urandom_range(0, 99) < 97, 6'd0, rel, 1'($urandom), 1'b0, rev, avail);
      n = $urandom_range(0, 6);
      repeat (n)
        tick_beat($urandom_range(0, 99) < 95, $urandom_range(0, 99) < 65,
                  $urandom_range(0, 99) < 60);
    end
  endtask

  initial begin : stimulus
    int unsigned      half, goal, k, sat_from;
    logic [REV_W-1:0] rev;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = ACT_SCAN;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---- directed: reset settings (usb link, 2000 ms), time frozen near wrap ----
    scan_beat(1'b1, 6'd0, 7'd0, 1'b1, 1'b0, 8'h00, 5'h1F);       // neutral frame
    scan_beat(1'b0, 6'h3F, 7'h7F, 1'b0, 1'b1, 8'hFF, 5'h1F);     // bad frame, all bits up
    scan_beat(1'b1, 6'h02, 7'h40, 1'b0, 1'b1, 8'hFF, 5'h1F);     // Fn+key1 pending
    scan_beat(1'b1, 6'h00, 7'h42, 1'b0, 1'b1, 8'hFF, 5'h1F);     // still held
    scan_beat(1'b1, 6'h00, 7'h02, 1'b0, 1'b0, 8'hFF, 5'h1F);     // Fn up: switch to 1
    tick_beat(1'b1, 1'b1, 1'b0);                                 // select fails
    tick_beat(1'b1, 1'b0, 1'b1);                                 // host busy
    tick_beat(1'b1, 1'b1, 1'b1);                                 // switch completes
    scan_beat(1'b1, 6'd0, 7'd0, 1'b0, 1'b0, 8'hFF, 5'h1F);       // not yet neutral
    scan_beat(1'b1, 6'd0, 7'd0, 1'b1, 1'b0, 8'hFF, 5'h1F);       // neutral reached
    scan_beat(1'b1, 6'h20, 7'h40, 1'b0, 1'b1, 8'h5A, 5'h00);     // battery key
    scan_beat(1'b1, 6'h00, 7'h20, 1'b0, 1'b0, 8'h5A, 5'h00);     // battery confirmed, no switch
    scan_beat(1'b1, 6'd0, 7'd0, 1'b1, 1'b0, 8'h5A, 5'h1F);
    scan_beat(1'b1, 6'h02, 7'h40, 1'b0, 1'b1, 8'h5A, 5'h1F);     // choose the current link
    scan_beat(1'b1, 6'h00, 7'h40, 1'b0, 1'b1, 8'h5A, 5'h1F);     // key up: no switch
    scan_beat(1'b1, 6'd0, 7'd0, 1'b1, 1'b0, 8'h5A, 5'h1F);
    scan_beat(1'b1, 6'h08, 7'h40, 1'b0, 1'b1, 8'h5A, 5'h17);     // unavailable choice
    scan_beat(1'b1, 6'h05, 7'h40, 1'b0, 1'b1, 8'h5A, 5'h1F);     // two new presses at once
    scan_beat(1'b1, 6'h00, 7'h00, 1'b0, 1'b0, 8'h5A, 5'h1F);
    scan_beat(1'b1, 6'h01, 7'h40, 1'b0, 1'b1, 8'hAA, 5'h1F);     // key0 pending
    scan_beat(1'b1, 6'h00, 7'h41, 1'b0, 1'b1, 8'h55, 5'h1F);     // revision moved: dropped
    scan_beat(1'b1, 6'd0, 7'd0, 1'b1, 1'b0, 8'hAA, 5'h1F);
    scan_beat(1'b1, 6'h10, 7'h40, 1'b0, 1'b1, 8'hAA, 5'h1F);     // key4 back to usb
    scan_beat(1'b1, 6'h00, 7'h10, 1'b0, 1'b0, 8'hAA, 5'h1F);
    now_ms = now_ms + 32'd2000;                                  // exactly the timeout, wrapped
    tick_beat(1'b1, 1'b1, 1'b1);
    tick_beat(1'b0, 1'b1, 1'b1);                                 // stale tick, no switch running

    // ---- directed register writes: ignored ones, a masked rebind, zero timeout ----
    drain_results();
    write_reg(CFG_TIMEOUT, 16'd0);
    write_reg(CFG_START_LINK, 16'd7);
    write_reg(CFG_START_LINK, 16'd5);
    write_reg(8'd2, 16'd3);
    write_reg(8'hFF, 16'hFFFF);
    write_reg(CFG_START_LINK, 16'hFFF9);                         // low bits give link 1
    scan_beat(1'b1, 6'd0, 7'd0, 1'b1, 1'b0, 8'h00, 5'h1F);
    scan_beat(1'b1, 6'h01, 7'h40, 1'b0, 1'b1, 8'h00, 5'h1F);
    scan_beat(1'b1, 6'h00, 7'h01, 1'b0, 1'b0, 8'h00, 5'h1F);
    tick_beat(1'b1, 1'b1, 1'b1);                                 // times out at once

    // ---- random phases, one setting each ----
    clock_run = 1'b1;
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      if ($urandom_range(0, 1))
        write_reg(CFG_IDX_W'($urandom_range(2, 255)), CFG_DATA_W'($urandom));
      else
        write_reg(CFG_START_LINK, CFG_DATA_W'($urandom_range(5, 7)) |
                                  (CFG_DATA_W'($urandom) & 16'hFFF8));
      write_reg(CFG_START_LINK, {13'($urandom), start_tab[ph]});
      write_reg(CFG_TIMEOUT, tmo_tab[ph]);
      rx_free = (ph == 4);
      tx_free = (ph == 4);
      half = beats_sent + PHASE_BEATS / 2;
      goal = beats_sent + PHASE_BEATS;
      while (beats_sent < half) random_traffic();
      case (ph)
        1: begin
          // sink stalls for a long stretch while the source keeps pushing
          hold_req = 1'b1;
          tx_free  = 1'b1;
          repeat (4) random_traffic();
          tx_free  = 1'b0;
        end
        3: drain_results();   // source pauses until the pipe is empty
        4: begin
          rx_free = 1'b0;
          tx_free = 1'b0;
        end
        default: ;
      endcase
      while (beats_sent < goal) random_traffic();
    end

    // ---- failed switches at full rate: a stale frame lands mid-switch each round ----
    drain_results();
    write_reg(CFG_START_LINK, {13'd0, USB_LINK});
    write_reg(CFG_TIMEOUT, 16'hFFFF);
    clock_run = 1'b0;
    rx_free   = 1'b1;
    tx_free   = 1'b1;
    sat_from  = beats_sent;
    for (int n = 0; n < SAT_ROUNDS; n++) begin
      k   = $urandom_range(0, 3);
      rev = REV_W'($urandom);
      scan_beat(1'b1, 6'd0, 7'd0, 1'b1, 1'b0, rev, 5'h1F);
      scan_beat(1'b1, 6'd1 << k, 7'h40, 1'b0, 1'b1, rev, 5'h1F);
      scan_beat(1'b1, 6'd0, 7'd1 << k, 1'b0, 1'b0, rev, 5'h1F);
      tick_beat(1'b0, 1'($urandom), 1'($urandom));              // stale frame mid-switch
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run: %0d input beats, %0d result beats checked, %0d random settings phases",
             beats_sent, results_checked, PHASES);
    $display("Run: %0d beats drove the error count to %0d",
             beats_sent - sat_from, error_level);
    if (fail_count == 0 && awaiting == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// File: files.f
rtl/kcls_pkg.sv
rtl/key_combo_link_selector_unit.sv
tb/kcls_checker.sv
tb/key_combo_link_selector_unit_tb.sv
